// ===== hw/rtl/assert_macros.svh =====
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// property holds at every clock edge outside reset
`define ASSERT_AT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");
// condition never seen at a clock edge outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("forbidden condition seen");
`else
`define ASSERT_AT(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

// ===== hw/rtl/clti_pkg.sv =====
// types and constants of the core-local timer interruptor
package clti_pkg;

	// command codes
	localparam logic [1:0] CMD_READ  = 2'd0;
	localparam logic [1:0] CMD_WRITE = 2'd1;
	localparam logic [1:0] CMD_TICK  = 2'd2;

	// configuration register indexes
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_HARTS_IN_USE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SHIM_MODE    = 2'd1;

	// register map
	localparam logic [15:0] CMP_BASE     = 16'h4000;
	localparam logic [15:0] TIME_ADDR    = 16'hbff8;
	localparam logic [15:0] TIME_ADDR_HI = 16'hbffc;
	localparam logic [2:0]  WORD_LEN     = 3'd4;

	// harts visible on the line outputs
	localparam int LINE_HARTS = 4;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [15:0] offset;
		logic [2:0]  access_len;
		logic [31:0] write_data;
	} req_t;

	typedef struct packed {
		logic [31:0] read_data;
		logic        access_ok;
		logic [3:0]  soft_lines;
		logic [3:0]  mach_timer_lines;
		logic [3:0]  super_timer_lines;
		logic [3:0]  wake_pulse;
		logic [31:0] time_low;
	} rsp_t;

	// decoded access
	typedef struct packed {
		logic       ok;
		logic       tick;
		logic       wr;
		logic       soft_hit;
		logic       cmp_hit;
		logic       time_hit;
		logic       hi;
		logic [2:0] hart;
	} dec_t;

endpackage

// ===== hw/rtl/clti_decode.sv =====
// address and command decoder of the core-local timer interruptor
module clti_decode #(
	parameter int REGION_BYTES = 65536
) (
	input  clti_pkg::req_t req,
	input  logic [2:0]     harts,
	output clti_pkg::dec_t dec
);

	logic access;
	logic aligned;
	logic in_soft;
	logic in_cmp;

	assign access = ((req.cmd == clti_pkg::CMD_READ) || (req.cmd == clti_pkg::CMD_WRITE))
		&& (req.access_len == clti_pkg::WORD_LEN)
		&& ({1'b0, req.offset} < 17'(REGION_BYTES));
	assign aligned = (req.offset[1:0] == 2'b00);
	// soft words sit at 4*h, compare pairs at base + 8*h
	assign in_soft = (req.offset[15:5] == 11'b0) && (req.offset[4:0] < {harts, 2'b00});
	assign in_cmp  = (req.offset[15:6] == clti_pkg::CMP_BASE[15:6])
		&& (req.offset[5:0] < {harts, 3'b000});

	always_comb begin
		dec = '0;
		if (req.cmd == clti_pkg::CMD_TICK) begin
			dec.ok   = 1'b1;
			dec.tick = 1'b1;
		end else if (access) begin
			dec.wr = (req.cmd == clti_pkg::CMD_WRITE);
			if (in_soft) begin
				if (aligned) begin
					dec.ok       = 1'b1;
					dec.soft_hit = 1'b1;
					dec.hart     = req.offset[4:2];
				end
			end else if (in_cmp) begin
				if (aligned) begin
					dec.ok      = 1'b1;
					dec.cmp_hit = 1'b1;
					dec.hart    = req.offset[5:3];
					dec.hi      = req.offset[2];
				end
			end else begin
				// anything else in the region, but the time words, reads zero and drops writes
				dec.ok = 1'b1;
				if ((req.offset == clti_pkg::TIME_ADDR) || (req.offset == clti_pkg::TIME_ADDR_HI)) begin
					dec.time_hit = 1'b1;
					dec.hi       = req.offset[2];
				end
			end
		end
	end

endmodule

// ===== hw/rtl/core_local_timer_interruptor_core.sv =====
// top level of the core-local timer interruptor
// Core-local timer and software-interrupt block. Each request word is a bus read,
// a bus write or one timer tick; each gives exactly one response word with read
// data, an ok flag, the per-hart soft, machine-timer and supervisor-timer lines,
// wake pulses and the low half of the time counter after the step. A word is
// taken every cycle unless a waiting response stalls the input register; the word
// passes through two registers, one input register and one result register,
// with the 64-bit time update and the per-hart time >= compare checks done in
// parallel in the single stage between them; the result register presents the response.
// A response that waits at the output holds the next word in the input register.
// All state is cleared by reset (compare values to all ones), no clearing pass.
// Configuration writes are always taken and belong in idle periods.
`include "assert_macros.svh"

module core_local_timer_interruptor_core #(
	parameter int MAX_HARTS    = 4,
	parameter int REGION_BYTES = 65536
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  req_valid,
	output logic                                  req_ready,
	input  clti_pkg::req_t                        req,
	output logic                                  rsp_valid,
	input  logic                                  rsp_ready,
	output clti_pkg::rsp_t                        rsp,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [clti_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [clti_pkg::CFG_DATA_W-1:0]       cfg_data
);

	localparam int MAX_N = (MAX_HARTS < 7) ? MAX_HARTS : 7;

	// configuration
	logic [2:0] harts_q;
	logic       shim_q;
	logic [2:0] harts_act;

	// state
	logic [63:0]          time_q;
	logic [63:0]          cmp_q [MAX_HARTS];
	logic [MAX_HARTS-1:0] soft_q;
	logic [MAX_HARTS-1:0] mach_q;
	logic [MAX_HARTS-1:0] super_q;

	// pipeline
	logic            valid_s1;
	clti_pkg::req_t  req_s1;
	logic            fire_s1;
	logic            rsp_valid_q;
	clti_pkg::rsp_t  rsp_q;
	clti_pkg::dec_t  dec;

	// next values
	logic [63:0]          time_next;
	logic [63:0]          cmp_next [MAX_HARTS];
	logic [MAX_HARTS-1:0] soft_next;
	logic [MAX_HARTS-1:0] mach_next;
	logic [MAX_HARTS-1:0] super_next;
	logic [MAX_HARTS-1:0] wake;
	logic [31:0]          rdata;
	logic [3:0]           soft_lines;
	logic [3:0]           mach_lines;
	logic [3:0]           super_lines;
	logic [3:0]           wake_lines;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			harts_q <= 3'd1;
			shim_q  <= 1'b0;
		end else if (cfg_valid) begin
			if (cfg_index == clti_pkg::CFG_HARTS_IN_USE) begin
				harts_q <= cfg_data[2:0];
			end else if (cfg_index == clti_pkg::CFG_SHIM_MODE) begin
				shim_q <= cfg_data[0];
			end
		end
	end

	assign harts_act = (int'(harts_q) > MAX_N) ? 3'(MAX_N) : harts_q;

	// handshake: input register advances when the result register is free
	assign fire_s1   = valid_s1 && (!rsp_valid_q || rsp_ready);
	assign req_ready = !valid_s1 || fire_s1;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			req_s1 <= req;
		end
	end

	clti_decode #(
		.REGION_BYTES(REGION_BYTES)
	) u_decode (
		.req  (req_s1),
		.harts(harts_act),
		.dec  (dec)
	);

	always_comb begin
		logic        sel;
		logic        refresh;
		logic        expired;
		logic        soft_rd;
		logic [63:0] cmp_rd;
		soft_rd = 1'b0;
		cmp_rd  = '0;
		time_next = time_q;
		if (dec.tick) begin
			time_next = time_q + 64'd1;
		end else if (dec.time_hit && dec.wr) begin
			if (dec.hi) begin
				time_next = {req_s1.write_data, time_q[31:0]};
			end else begin
				time_next = {time_q[63:32], req_s1.write_data};
			end
		end
		wake = '0;
		for (int g = 0; g < MAX_HARTS; g++) begin
			sel = (int'(dec.hart) == g);
			if (sel) begin
				soft_rd = soft_q[g];
				cmp_rd  = cmp_q[g];
			end
			soft_next[g] = soft_q[g];
			if (dec.soft_hit && dec.wr && sel) begin
				soft_next[g] = req_s1.write_data[0];
				wake[g]      = req_s1.write_data[0];
			end
			cmp_next[g] = cmp_q[g];
			if (dec.cmp_hit && dec.wr && sel) begin
				if (dec.hi) begin
					cmp_next[g] = {req_s1.write_data, cmp_q[g][31:0]};
				end else begin
					cmp_next[g] = {cmp_q[g][63:32], req_s1.write_data};
				end
			end
			// a tick or time write refreshes every hart in use, a compare write its own hart
			refresh = ((dec.tick || (dec.time_hit && dec.wr)) && (g < int'(harts_act)))
				|| (dec.cmp_hit && dec.wr && sel);
			expired = (time_next >= cmp_next[g]);
			mach_next[g]  = mach_q[g];
			super_next[g] = super_q[g];
			if (refresh) begin
				if (shim_q) begin
					super_next[g] = expired;
					mach_next[g]  = 1'b0;
				end else begin
					mach_next[g] = expired;
				end
			end
		end
		rdata = '0;
		if (!dec.wr) begin
			if (dec.soft_hit) begin
				rdata = {31'b0, soft_rd};
			end else if (dec.cmp_hit) begin
				rdata = dec.hi ? cmp_rd[63:32] : cmp_rd[31:0];
			end else if (dec.time_hit) begin
				rdata = dec.hi ? time_q[63:32] : time_q[31:0];
			end
		end
	end

	for (genvar g = 0; g < clti_pkg::LINE_HARTS; g++) begin : g_line
		if (g < MAX_HARTS) begin : g_used
			assign soft_lines[g]  = soft_next[g];
			assign mach_lines[g]  = mach_next[g];
			assign super_lines[g] = super_next[g];
			assign wake_lines[g]  = wake[g];
		end else begin : g_none
			assign soft_lines[g]  = 1'b0;
			assign mach_lines[g]  = 1'b0;
			assign super_lines[g] = 1'b0;
			assign wake_lines[g]  = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_q  <= '0;
			soft_q  <= '0;
			mach_q  <= '0;
			super_q <= '0;
			for (int g = 0; g < MAX_HARTS; g++) begin
				cmp_q[g] <= '1;
			end
		end else if (fire_s1) begin
			time_q  <= time_next;
			soft_q  <= soft_next;
			mach_q  <= mach_next;
			super_q <= super_next;
			for (int g = 0; g < MAX_HARTS; g++) begin
				cmp_q[g] <= cmp_next[g];
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (fire_s1) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			rsp_q.read_data         <= rdata;
			rsp_q.access_ok         <= dec.ok;
			rsp_q.soft_lines        <= soft_lines;
			rsp_q.mach_timer_lines  <= mach_lines;
			rsp_q.super_timer_lines <= super_lines;
			rsp_q.wake_pulse        <= wake_lines;
			rsp_q.time_low          <= time_next[31:0];
		end
	end

	`ASSERT_AT(a_wake_sets_soft, clk, arst_n, rsp_valid |-> ((rsp.wake_pulse & ~rsp.soft_lines) == 4'b0))
	`ASSERT_NEVER(a_err_no_data, clk, arst_n, rsp_valid && !rsp.access_ok && (rsp.read_data != 32'b0))
	`ASSERT_AT(a_tick_counts, clk, arst_n, (fire_s1 && dec.tick) |=> (time_q == $past(time_q) + 64'd1))
	`ASSERT_AT(a_one_target, clk, arst_n, valid_s1 |-> $onehot0({dec.tick, dec.soft_hit, dec.cmp_hit, dec.time_hit}))

endmodule

// ===== test/testbench.sv =====
// self-checking testbench of the core-local timer interruptor core
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import clti_pkg::*;

	localparam int HARTS = 4;
	localparam int PHASES = 8;
	localparam int PHASE_WORDS = 150;
	localparam int DRAIN_LIMIT = 100000;
	localparam int PRINT_LIMIT = 100;
	localparam logic [1:0] CMD_UNKNOWN = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// predicted state of the block
	logic [63:0] mtime;
	logic [63:0] mtimecmp [HARTS];
	logic [HARTS-1:0] msip;
	logic [HARTS-1:0] mtip;
	logic [HARTS-1:0] stip;
	logic [2:0] harts_cfg;
	logic shim_cfg;

	rsp_t pending_rsps [$];
	rsp_t want_rsp;
	int errors = 0;
	int burst_left = 0;
	int stall_left = 0;
	int stall_mode = 0;

	core_local_timer_interruptor_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	initial begin
		#5000000;
		$display("Some tests failed");
		$finish;
	end

	function automatic void clint_reset();
		mtime = 64'd0;
		for (int h = 0; h < HARTS; h++) begin
			mtimecmp[h] = '1;
		end
		msip = '0;
		mtip = '0;
		stip = '0;
		harts_cfg = 3'd1;
		shim_cfg = 1'b0;
	endfunction

	function automatic void refresh_hart(int unsigned h);
		logic expired;
		expired = (mtime >= mtimecmp[h]);
		if (shim_cfg) begin
			stip[h] = expired;
			mtip[h] = 1'b0;
		end else begin
			mtip[h] = expired;
		end
	endfunction

	function automatic void refresh_all(int unsigned n);
		for (int unsigned h = 0; h < n; h++) begin
			refresh_hart(h);
		end
	endfunction

	// state update and response word of one request word
	function automatic rsp_t clint_step(req_t r);
		rsp_t o;
		int unsigned n;
		int unsigned off;
		int unsigned rel;
		int unsigned h;
		logic wr;
		logic hi;
		o = '0;
		n = (harts_cfg > HARTS) ? HARTS : harts_cfg;
		off = r.offset;
		if (r.cmd == CMD_TICK) begin
			mtime = mtime + 64'd1;
			refresh_all(n);
			o.access_ok = 1'b1;
		end else if ((r.cmd == CMD_READ || r.cmd == CMD_WRITE) && r.access_len == WORD_LEN) begin
			// a 16-bit offset always lies inside the region
			wr = (r.cmd == CMD_WRITE);
			if (off < n * 4) begin
				if (off % 4 == 0) begin
					h = off / 4;
					o.access_ok = 1'b1;
					if (wr) begin
						msip[h] = r.write_data[0];
						if (r.write_data[0]) begin
							o.wake_pulse[h] = 1'b1;
						end
					end else begin
						o.read_data = {31'd0, msip[h]};
					end
				end
			end else if (off >= CMP_BASE && off < CMP_BASE + n * 8) begin
				rel = off - CMP_BASE;
				if (rel % 4 == 0) begin
					h = rel / 8;
					hi = (rel % 8 != 0);
					o.access_ok = 1'b1;
					if (wr) begin
						if (hi) begin
							mtimecmp[h][63:32] = r.write_data;
						end else begin
							mtimecmp[h][31:0] = r.write_data;
						end
						refresh_hart(h);
					end else begin
						o.read_data = hi ? mtimecmp[h][63:32] : mtimecmp[h][31:0];
					end
				end
			end else begin
				o.access_ok = 1'b1;
				if (r.offset == TIME_ADDR || r.offset == TIME_ADDR_HI) begin
					hi = (r.offset == TIME_ADDR_HI);
					if (wr) begin
						if (hi) begin
							mtime[63:32] = r.write_data;
						end else begin
							mtime[31:0] = r.write_data;
						end
						refresh_all(n);
					end else begin
						o.read_data = hi ? mtime[63:32] : mtime[31:0];
					end
				end
			end
		end
		o.soft_lines = msip;
		o.mach_timer_lines = mtip;
		o.super_timer_lines = stip;
		o.time_low = mtime[31:0];
		return o;
	endfunction

	// sender: bursts of words with random gaps between them
	task automatic send_word(req_t r);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		req_valid <= 1'b1;
		req <= r;
		do @(posedge clk); while (!req_ready);
		pending_rsps.push_back(clint_step(r));
	endtask

	task automatic bus_word(logic [1:0] cmd, logic [15:0] off, logic [2:0] len, logic [31:0] data);
		req_t r;
		r.cmd = cmd;
		r.offset = off;
		r.access_len = len;
		r.write_data = data;
		send_word(r);
	endtask

	task automatic wait_idle();
		req_valid <= 1'b0;
		burst_left = 0;
		while (pending_rsps.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx == CFG_HARTS_IN_USE) begin
			harts_cfg = val;
		end else if (idx == CFG_SHIM_MODE) begin
			shim_cfg = val[0];
		end
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// receiver: ready pattern picks one of four modes, each kept for a random run
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode <= $urandom_range(0, 3);
			stall_left <= $urandom_range(8, 80);
		end else begin
			stall_left <= stall_left - 1;
		end
		case (stall_mode)
			0: rsp_ready <= 1'b1;
			1: rsp_ready <= ($urandom_range(0, 1) == 1);
			2: rsp_ready <= ($urandom_range(0, 7) != 0);
			default: rsp_ready <= ($urandom_range(0, 3) == 0);
		endcase
	end

	task automatic report_field(string name, logic [31:0] want_v, logic [31:0] got_v);
		if (errors < PRINT_LIMIT) begin
			$display("%0t: %s mismatch: expected %h, got %h", $time, name, want_v, got_v);
		end
		errors++;
	endtask

	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready) begin
			if (pending_rsps.size() == 0) begin
				if (errors < PRINT_LIMIT) begin
					$display("%0t: response word with none expected: %p", $time, rsp);
				end
				errors++;
			end else begin
				want_rsp = pending_rsps.pop_front();
				if (rsp.read_data !== want_rsp.read_data)
					report_field("read_data", want_rsp.read_data, rsp.read_data);
				if (rsp.access_ok !== want_rsp.access_ok)
					report_field("access_ok", want_rsp.access_ok, rsp.access_ok);
				if (rsp.soft_lines !== want_rsp.soft_lines)
					report_field("soft_lines", want_rsp.soft_lines, rsp.soft_lines);
				if (rsp.mach_timer_lines !== want_rsp.mach_timer_lines)
					report_field("mach_timer_lines", want_rsp.mach_timer_lines,
						rsp.mach_timer_lines);
				if (rsp.super_timer_lines !== want_rsp.super_timer_lines)
					report_field("super_timer_lines", want_rsp.super_timer_lines,
						rsp.super_timer_lines);
				if (rsp.wake_pulse !== want_rsp.wake_pulse)
					report_field("wake_pulse", want_rsp.wake_pulse, rsp.wake_pulse);
				if (rsp.time_low !== want_rsp.time_low)
					report_field("time_low", want_rsp.time_low, rsp.time_low);
			end
		end
	end

	task automatic test_reset_values();
		bus_word(CMD_READ, TIME_ADDR, WORD_LEN, 32'h0);
		bus_word(CMD_READ, TIME_ADDR_HI, WORD_LEN, 32'h0);
		bus_word(CMD_READ, CMP_BASE + 16'h4, WORD_LEN, 32'h0);
	endtask

	task automatic test_access_errors();
		bus_word(CMD_READ, TIME_ADDR, 3'd0, 32'h0);
		bus_word(CMD_WRITE, 16'h0000, 3'd7, 32'hffff_ffff);
		bus_word(CMD_UNKNOWN, 16'h0000, WORD_LEN, 32'hffff_ffff);
		bus_word(CMD_READ, 16'h0001, WORD_LEN, 32'h0);
		bus_word(CMD_WRITE, CMP_BASE + 16'h2, WORD_LEN, 32'h0);
		// misaligned time offset is just an unused word
		bus_word(CMD_READ, TIME_ADDR + 16'h1, WORD_LEN, 32'h0);
		bus_word(CMD_WRITE, 16'hffff, WORD_LEN, 32'hffff_ffff);
	endtask

	task automatic test_soft_bits();
		bus_word(CMD_WRITE, 16'h0000, WORD_LEN, 32'h1);
		bus_word(CMD_READ, 16'h0000, WORD_LEN, 32'h0);
		bus_word(CMD_WRITE, 16'h0000, WORD_LEN, 32'hffff_fffe);
	endtask

	task automatic test_time_and_compare();
		bus_word(CMD_WRITE, TIME_ADDR, WORD_LEN, 32'hffff_ffff);
		bus_word(CMD_WRITE, TIME_ADDR_HI, WORD_LEN, 32'hffff_ffff);
		// time wraps to zero
		bus_word(CMD_TICK, 16'hffff, 3'd7, 32'hffff_ffff);
		bus_word(CMD_WRITE, CMP_BASE, WORD_LEN, 32'h2);
		bus_word(CMD_WRITE, CMP_BASE + 16'h4, WORD_LEN, 32'h0);
		bus_word(CMD_TICK, 16'h0000, 3'd0, 32'h0);
		bus_word(CMD_TICK, 16'h0000, 3'd0, 32'h0);
	endtask

	task automatic test_hart_count();
		write_reg(CFG_HARTS_IN_USE, 3'd0);
		bus_word(CMD_READ, 16'h0000, WORD_LEN, 32'h0);
		bus_word(CMD_READ, CMP_BASE, WORD_LEN, 32'h0);
		// above the maximum acts as the maximum
		write_reg(CFG_HARTS_IN_USE, 3'd7);
		bus_word(CMD_WRITE, 16'h000c, WORD_LEN, 32'h1);
		bus_word(CMD_READ, CMP_BASE + 16'h1c, WORD_LEN, 32'h0);
	endtask

	task automatic test_shim_mode();
		write_reg(CFG_SHIM_MODE, 3'd1);
		// lines hold until the next tick
		bus_word(CMD_READ, TIME_ADDR, WORD_LEN, 32'h0);
		bus_word(CMD_TICK, 16'h0000, WORD_LEN, 32'h0);
		write_reg(CFG_SHIM_MODE, 3'd0);
		bus_word(CMD_TICK, 16'h0000, WORD_LEN, 32'h0);
	endtask

	// mostly values near each other so that time and compare cross often
	function automatic logic [31:0] random_data();
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 40) return $urandom_range(0, 40);
		else if (pick < 55) return 32'hffff_ffff;
		else if (pick < 65) return 32'h0;
		else return $urandom;
	endfunction

	function automatic req_t random_word();
		req_t r;
		int unsigned pick;
		pick = $urandom_range(0, 99);
		r.cmd = ($urandom_range(0, 1) == 1) ? CMD_WRITE : CMD_READ;
		r.offset = 16'h0;
		r.access_len = WORD_LEN;
		r.write_data = random_data();
		if (pick < 15) begin
			r.cmd = CMD_TICK;
			r.offset = 16'($urandom);
			r.access_len = 3'($urandom);
			r.write_data = $urandom;
		end else if (pick < 35) begin
			r.offset = 16'(4 * $urandom_range(0, 4));
		end else if (pick < 65) begin
			r.offset = CMP_BASE + 16'(4 * $urandom_range(0, 9));
		end else if (pick < 80) begin
			r.offset = ($urandom_range(0, 1) == 1) ? TIME_ADDR_HI : TIME_ADDR;
		end else if (pick < 90) begin
			r.cmd = 2'($urandom);
			r.offset = 16'($urandom);
			r.access_len = 3'($urandom);
			r.write_data = $urandom;
		end else begin
			// misaligned word near a decoded register, or a wrong size
			case ($urandom_range(0, 3))
				0: r.offset = 16'(4 * $urandom_range(0, 3) + $urandom_range(1, 3));
				1: r.offset = CMP_BASE + 16'(4 * $urandom_range(0, 7) + $urandom_range(1, 3));
				2: r.offset = TIME_ADDR + 16'($urandom_range(1, 7));
				default: begin
					r.offset = CMP_BASE + 16'(4 * $urandom_range(0, 7));
					r.access_len = WORD_LEN ^ 3'($urandom_range(1, 7));
				end
			endcase
		end
		return r;
	endfunction

	task automatic test_random();
		logic [2:0] harts;
		logic shim;
		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: begin harts = 3'd4; shim = 1'b0; end
				1: begin harts = 3'd4; shim = 1'b1; end
				2: begin harts = 3'd0; shim = 1'b0; end
				3: begin harts = 3'd7; shim = 1'b1; end
				4: begin harts = 3'd1; shim = 1'b1; end
				default: begin
					harts = 3'($urandom_range(0, 7));
					shim = 1'($urandom);
				end
			endcase
			write_reg(CFG_HARTS_IN_USE, harts);
			write_reg(CFG_SHIM_MODE, {2'b00, shim});
			for (int i = 0; i < PHASE_WORDS; i++) begin
				// hold off until the pipeline has emptied
				if (i == PHASE_WORDS / 2) wait_idle();
				send_word(random_word());
			end
		end
	endtask

	initial begin
		int unsigned wait_cycles;
		clint_reset();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_values();
		test_access_errors();
		test_soft_bits();
		test_time_and_compare();
		test_hart_count();
		test_shim_mode();
		test_random();
		req_valid <= 1'b0;
		wait_cycles = 0;
		while (pending_rsps.size() != 0 && wait_cycles < DRAIN_LIMIT) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (10) @(posedge clk);
		if (pending_rsps.size() != 0) begin
			$display("%0t: %0d response words never arrived", $time, pending_rsps.size());
			errors++;
		end
		if (errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/clti_pkg.sv
hw/rtl/clti_decode.sv
hw/rtl/core_local_timer_interruptor_core.sv
test/testbench.sv
